// ===== sv/hcp_pkg.sv =====
// Shared types and constants for the Huffman code packer.
// No dependencies; used by every module of the block.
package hcp_pkg;

   localparam int BYTE_W           = 8;
   localparam int CODE_W           = 32;
   localparam int LEN_W            = 6;
   localparam int SYM_W            = 8;
   localparam int MAX_BYTES        = 4;
   localparam int CNT_W            = 3;
   localparam int SYMBOLS_DEF      = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [CODE_W-1:0] bits;
   } entry_type;

   typedef struct packed {
      logic      hit;
      entry_type entry;
   } lookup_type;

endpackage

// ===== sv/huffman_code_packer.sv =====
// Huffman code packer top level: code table memory, lookup stage and bit packer.
// Depends on hcp_pkg, hcp_code_table and hcp_bit_packer.
//
// Usage:
//   req_* carries one item: a load (writes a symbol's code length and bits),
//   an encode (appends the symbol's code LSB first to the pending byte) or a
//   flush (emits the partial byte, zero padded, if any bits are pending).
//   rsp_* carries packed bytes, earliest bit in bit 0; rsp_last marks the
//   final byte caused by one item.
// Ordering: an item's table entry is read into the lookup stage at acceptance;
//   its bytes are registered into the output buffer when the packer takes the
//   item, and rsp is driven from that buffer.
// Throughput: one item per cycle while items emit no bytes; otherwise the
//   byte-wide result port sets the pace, one byte per cycle while rsp_ready
//   is high; an encode completes at most four bytes.
// Reset: synchronous; clears all table valid bits (every symbol reads as
//   length zero), the pending byte and the output buffer. No clearing pass.
// Stall: a stalled rsp holds its byte; one further item waits in the lookup
//   stage, and req_ready drops until the output buffer can take its bytes.
module huffman_code_packer #(
   parameter int SYMBOLS      = hcp_pkg::SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [hcp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hcp_pkg::LEN_W-1:0]   req_code_length,
   input  logic [hcp_pkg::CODE_W-1:0]  req_code_bits,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hcp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last
);

   logic                 s1_valid_ff;
   hcp_pkg::opcode_type  s1_op_ff;
   hcp_pkg::lookup_type  lookup;
   logic                 take;
   logic                 req_fire;
   hcp_pkg::opcode_type  req_op;

   assign req_op    = hcp_pkg::opcode_type'(req_opcode);
   assign req_ready = !s1_valid_ff || take;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff <= req_op;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (take) begin
         s1_valid_ff <= 1'b0;
      end
   end

   hcp_code_table #(
      .SYMBOLS      (SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (req_fire && req_op == hcp_pkg::OP_LOAD),
      .rd_en       (req_fire && req_op == hcp_pkg::OP_ENCODE),
      .symbol      (req_symbol),
      .code_length (req_code_length),
      .code_bits   (req_code_bits),
      .lookup      (lookup)
   );

   hcp_bit_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_op        (s1_op_ff),
      .lookup       (lookup),
      .take         (take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== sv/hcp_code_table.sv =====
// Code table: one synchronous memory of code length and code bits per symbol,
// with per-entry valid bits cleared at reset. Depends on hcp_pkg.
module hcp_code_table #(
   parameter int SYMBOLS      = hcp_pkg::SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [hcp_pkg::SYM_W-1:0]   symbol,
   input  logic [hcp_pkg::LEN_W-1:0]   code_length,
   input  logic [hcp_pkg::CODE_W-1:0]  code_bits,
   output hcp_pkg::lookup_type         lookup
);

   localparam int AW    = $clog2(SYMBOLS);
   localparam int LIMIT = (MAX_CODE_LEN < hcp_pkg::CODE_W) ? MAX_CODE_LEN : hcp_pkg::CODE_W;

   hcp_pkg::entry_type mem [SYMBOLS];
   logic [SYMBOLS-1:0] valid_ff;
   hcp_pkg::entry_type rd_data_ff;
   logic               hit_ff;

   logic               in_range;
   logic [AW-1:0]      addr;
   hcp_pkg::entry_type wr_entry;

   always_comb begin
      in_range = {1'b0, symbol} < (hcp_pkg::SYM_W+1)'(SYMBOLS);
      addr     = symbol[AW-1:0];
      wr_entry.bits   = code_bits;
      wr_entry.length = (code_length > hcp_pkg::LEN_W'(LIMIT)) ?
                        hcp_pkg::LEN_W'(LIMIT) : code_length;
   end

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         mem[addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en && in_range) begin
            valid_ff[addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= in_range && valid_ff[addr];
         end
      end
   end

   assign lookup.hit   = hit_ff;
   assign lookup.entry = rd_data_ff;

endmodule

// ===== sv/hcp_bit_packer.sv =====
// Bit packer: merges looked-up code bits with the pending byte and drains
// completed bytes through an output buffer, one per cycle while rsp_ready is high. Depends on hcp_pkg.
module hcp_bit_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  hcp_pkg::opcode_type         in_op,
   input  hcp_pkg::lookup_type         lookup,
   output logic                        take,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hcp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last
);

   localparam int MW = hcp_pkg::CODE_W + hcp_pkg::BYTE_W;

   logic [hcp_pkg::BYTE_W-1:0]       pbyte_ff, pbyte_in;
   logic [2:0]                       pcount_ff, pcount_in;
   logic [hcp_pkg::CODE_W-1:0]       buf_ff, buf_in;
   logic [hcp_pkg::CNT_W-1:0]        cnt_ff, cnt_in;

   logic [hcp_pkg::LEN_W-1:0]        len;
   logic [hcp_pkg::CODE_W-1:0]       mask;
   logic [hcp_pkg::CODE_W-1:0]       masked;
   logic [MW-1:0]                    merged;
   logic [hcp_pkg::LEN_W-1:0]        total;
   logic [hcp_pkg::CNT_W-1:0]        nbytes;
   logic [hcp_pkg::CODE_W-1:0]       emit_data;
   logic                             buf_free;
   logic                             rsp_fire;

   always_comb begin
      len    = (in_op == hcp_pkg::OP_ENCODE && lookup.hit) ? lookup.entry.length : '0;
      mask   = hcp_pkg::CODE_W'((33'd1 << len) - 33'd1);
      masked = lookup.entry.bits & mask;
      merged = (MW'(masked) << pcount_ff) | MW'(pbyte_ff);
      total  = hcp_pkg::LEN_W'(pcount_ff) + len;

      pbyte_in  = pbyte_ff;
      pcount_in = pcount_ff;
      nbytes    = '0;
      emit_data = merged[hcp_pkg::CODE_W-1:0];
      case (in_op)
         hcp_pkg::OP_ENCODE: begin
            nbytes    = total[hcp_pkg::LEN_W-1:3];
            pcount_in = total[2:0];
            case (nbytes)
               3'd0:    pbyte_in = merged[7:0];
               3'd1:    pbyte_in = merged[15:8];
               3'd2:    pbyte_in = merged[23:16];
               3'd3:    pbyte_in = merged[31:24];
               3'd4:    pbyte_in = merged[39:32];
               default: pbyte_in = '0;
            endcase
         end
         hcp_pkg::OP_FLUSH: begin
            nbytes    = (pcount_ff != 3'd0) ? hcp_pkg::CNT_W'(1) : '0;
            emit_data = hcp_pkg::CODE_W'(pbyte_ff);
            pbyte_in  = '0;
            pcount_in = 3'd0;
         end
         default: begin
         end
      endcase

      rsp_fire = rsp_valid && rsp_ready;
      buf_free = (cnt_ff == '0) || (cnt_ff == hcp_pkg::CNT_W'(1) && rsp_ready);
      take     = in_valid && (buf_free || nbytes == '0);

      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (take && nbytes != '0) begin
         buf_in = emit_data;
         cnt_in = nbytes;
      end else if (rsp_fire) begin
         buf_in = buf_ff >> hcp_pkg::BYTE_W;
         cnt_in = cnt_ff - hcp_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         pbyte_ff  <= '0;
         pcount_ff <= 3'd0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (take) begin
            pbyte_ff  <= pbyte_in;
            pcount_ff <= pcount_in;
         end
      end
   end

   assign rsp_valid    = cnt_ff != '0;
   assign rsp_out_byte = buf_ff[hcp_pkg::BYTE_W-1:0];
   assign rsp_last     = cnt_ff == hcp_pkg::CNT_W'(1);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (take && nbytes != '0) |-> buf_free)
      else $error("output buffer overwritten with bytes still pending");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= hcp_pkg::CNT_W'(hcp_pkg::MAX_BYTES))
      else $error("byte count above four");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (take && in_op == hcp_pkg::OP_FLUSH) |=> (pcount_ff == 3'd0 && pbyte_ff == '0))
      else $error("pending bits left after flush");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      (pcount_ff == 3'd0) |-> (pbyte_ff == '0))
      else $error("stale bits in empty pending byte");

endmodule
